### hw/rtl/sqvg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the sprite quad
// vertex generator. No dependencies; imported by sqvg_sine_rom and the top level.
`default_nettype none

package sqvg_pkg;

    // Angle resolution and quarter-wave geometry
    localparam int ANGLE_BITS = 12;
    localparam int QBITS      = ANGLE_BITS - 2;
    localparam int QLEN       = 1 << QBITS;

    localparam logic [63:0] PI_HALF_Q60 = 64'h1921_FB54_442D_1847;

    // Taylor series divisors (2n)(2n+1) for n = 1 .. 14
    localparam logic [63:0] DIVS [14] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // One sprite beat as held inside the block
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic [15:0]        angle;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [15:0]        tex_w;
        logic [15:0]        tex_h;
        logic [31:0]        color_rgba;
    } t_sprite;

    typedef logic [14:0] t_qtab [QLEN+1];

    // (a * b) >> 60, low 64 bits kept
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // Quarter wave round(32767 * sin(pi/2 * k / QLEN)), built at elaboration
    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        for (int k = 0; k <= QLEN; k++) begin
            x    = mul_q60(PI_HALF_Q60, 64'(k) << (60 - QBITS));
            x2   = mul_q60(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 14; n++) begin
                term = mul_q60(term, x2) / DIVS[n-1];
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            r = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            tab[k] = r[14:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    localparam logic [QBITS:0] QLEN_W = (QBITS+1)'(QLEN);

    // Full-turn sine from the quarter wave, Q1.15
    function automatic logic signed [15:0] sine_lookup(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]         quad;
        logic [QBITS:0]     k;
        logic [QBITS:0]     idx;
        logic signed [15:0] mag;
        quad = a[ANGLE_BITS-1 -: 2];
        k    = {1'b0, a[QBITS-1:0]};
        idx  = quad[0] ? (QLEN_W - k) : k;
        mag  = signed'({1'b0, QTAB[idx]});
        return quad[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sqvg_if.sv
// Valid/ready channel interfaces for sprite input beats and vertex output beats.
// No dependencies on the package: field widths are fixed by the channel format.
`default_nettype none

interface sqvg_sprite_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [15:0]        angle;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic [31:0]        color_rgba;

    modport source (
        output valid, pos_x, pos_y, scale_x, scale_y, angle,
               tex_u, tex_v, tex_w, tex_h, color_rgba,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, scale_x, scale_y, angle,
               tex_u, tex_v, tex_w, tex_h, color_rgba,
        output ready
    );
endinterface

interface sqvg_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        corner_u;
    logic [15:0]        corner_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last;

    modport source (
        output valid, vertex_x, vertex_y, corner_u, corner_v, vertex_color, corner, last,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, corner_u, corner_v, vertex_color, corner, last,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/sqvg_sine_rom.sv
// Registered-read sine and cosine lookup over the quarter-wave table.
// Depends on sqvg_pkg (ANGLE_BITS, sine_lookup).
`default_nettype none

module sqvg_sine_rom
    import sqvg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [15:0]         o_sin,
    output logic signed [15:0]         o_cos
);

    logic [ANGLE_BITS-1:0] w_cos_angle;
    logic signed [15:0]    r_sin;
    logic signed [15:0]    r_cos;

    // Cosine is the sine a quarter turn ahead
    assign w_cos_angle = i_angle + ANGLE_BITS'(QLEN);

    // Read both values on enable, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= sine_lookup(i_angle);
            r_cos <= sine_lookup(w_cos_angle);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

### hw/rtl/sprite_quad_vertex_generator.sv
// Top level of the sprite quad vertex generator.
// Depends on sqvg_pkg, sqvg_if.sv (channel interfaces) and sqvg_sine_rom.
`default_nettype none

// Takes one sprite beat (centre, full size, angle, texture rectangle, colour) and emits
// four vertex beats in the order (-hw,-hh), (hw,-hh), (hw,hh), (-hw,hh), one per cycle
// while the output is not stalled, with corner numbers 0 to 3 and last set on corner 3.
// The corner iterator that feeds the output register paces the sprites; the next sprite
// waits in the input register and stage B and enters the corner stage as corner 3 leaves.
// An accepted sprite passes the input register, the sine/cosine table read, the four
// half-size by sine/cosine products and the output register. Positions saturate to
// 32-bit signed and texture sums to 65535. The angle keeps its top ANGLE_BITS bits.
// No registers to configure.
module sprite_quad_vertex_generator
    import sqvg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sqvg_sprite_if.sink    i_sprite,
    sqvg_vertex_if.source  o_vertex
);

    // Saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = v[31:0];
        end else if (v[33]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Stage A: input register
    logic    r_a_vld;
    t_sprite r_a;

    // Stage B: half sizes, texture corners; sine/cosine from the table
    logic               r_b_vld;
    logic signed [30:0] r_b_hw;
    logic signed [30:0] r_b_hh;
    logic signed [31:0] r_b_pos_x;
    logic signed [31:0] r_b_pos_y;
    logic [15:0]        r_b_u0;
    logic [15:0]        r_b_u1;
    logic [15:0]        r_b_v0;
    logic [15:0]        r_b_v1;
    logic [31:0]        r_b_col;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    // Stage C: products and corner iterator
    logic               r_c_vld;
    logic [1:0]         r_corner;
    logic signed [46:0] r_c_hc;
    logic signed [46:0] r_c_hs;
    logic signed [46:0] r_c_vc;
    logic signed [46:0] r_c_vs;
    logic signed [31:0] r_c_pos_x;
    logic signed [31:0] r_c_pos_y;
    logic [15:0]        r_c_u0;
    logic [15:0]        r_c_u1;
    logic [15:0]        r_c_v0;
    logic [15:0]        r_c_v1;
    logic [31:0]        r_c_col;

    // Output register
    logic               r_o_vld;
    logic signed [31:0] r_o_x;
    logic signed [31:0] r_o_y;
    logic [15:0]        r_o_u;
    logic [15:0]        r_o_v;
    logic [31:0]        r_o_col;
    logic [1:0]         r_o_corner;
    logic               r_o_last;

    // Flow control
    logic w_out_free;
    logic w_c_adv;
    logic w_c_take;
    logic w_b_free;
    logic w_a_move;
    logic w_in_acc;

    assign w_out_free = !r_o_vld || o_vertex.ready;
    assign w_c_adv    = r_c_vld && w_out_free;
    assign w_c_take   = !r_c_vld || (w_c_adv && r_corner == CORNER_LAST);
    assign w_b_free   = !r_b_vld || w_c_take;
    assign w_a_move   = r_a_vld && w_b_free;
    assign i_sprite.ready = !r_a_vld || w_b_free;
    assign w_in_acc   = i_sprite.valid && i_sprite.ready;

    // Capture the sprite beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_sprite.ready) begin
            r_a_vld <= i_sprite.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a.pos_x      <= i_sprite.pos_x;
            r_a.pos_y      <= i_sprite.pos_y;
            r_a.scale_x    <= i_sprite.scale_x;
            r_a.scale_y    <= i_sprite.scale_y;
            r_a.angle      <= i_sprite.angle;
            r_a.tex_u      <= i_sprite.tex_u;
            r_a.tex_v      <= i_sprite.tex_v;
            r_a.tex_w      <= i_sprite.tex_w;
            r_a.tex_h      <= i_sprite.tex_h;
            r_a.color_rgba <= i_sprite.color_rgba;
        end
    end

    // Sine and cosine of the truncated angle
    sqvg_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_en    (w_a_move),
        .i_angle (r_a.angle[15 -: ANGLE_BITS]),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // Stage B: half sizes and saturated texture sums
    logic [16:0] w_u_sum;
    logic [16:0] w_v_sum;

    assign w_u_sum = {1'b0, r_a.tex_u} + {1'b0, r_a.tex_w};
    assign w_v_sum = {1'b0, r_a.tex_v} + {1'b0, r_a.tex_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_free) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_b_hw    <= r_a.scale_x[31:1];
            r_b_hh    <= r_a.scale_y[31:1];
            r_b_pos_x <= r_a.pos_x;
            r_b_pos_y <= r_a.pos_y;
            r_b_u0    <= r_a.tex_u;
            r_b_v0    <= r_a.tex_v;
            r_b_u1    <= w_u_sum[16] ? 16'hFFFF : w_u_sum[15:0];
            r_b_v1    <= w_v_sum[16] ? 16'hFFFF : w_v_sum[15:0];
            r_b_col   <= r_a.color_rgba;
        end
    end

    // Stage C: four products per sprite, then iterate over the corners
    logic w_b_move;

    assign w_b_move = r_b_vld && w_c_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld  <= 1'b0;
            r_corner <= 2'd0;
        end else if (w_c_take) begin
            r_c_vld  <= r_b_vld;
            r_corner <= 2'd0;
        end else if (w_c_adv) begin
            r_corner <= r_corner + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_c_hc    <= 47'(r_b_hw) * 47'(w_cos);
            r_c_hs    <= 47'(r_b_hw) * 47'(w_sin);
            r_c_vc    <= 47'(r_b_hh) * 47'(w_cos);
            r_c_vs    <= 47'(r_b_hh) * 47'(w_sin);
            r_c_pos_x <= r_b_pos_x;
            r_c_pos_y <= r_b_pos_y;
            r_c_u0    <= r_b_u0;
            r_c_u1    <= r_b_u1;
            r_c_v0    <= r_b_v0;
            r_c_v1    <= r_b_v1;
            r_c_col   <= r_b_col;
        end
    end

    // Corner combine: sign the products, floor shift, translate, saturate
    logic               w_x_neg;
    logic               w_y_neg;
    logic signed [46:0] w_hc;
    logic signed [46:0] w_hs;
    logic signed [46:0] w_vc;
    logic signed [46:0] w_vs;
    logic signed [47:0] w_rx_full;
    logic signed [47:0] w_ry_full;
    logic signed [33:0] w_x_sum;
    logic signed [33:0] w_y_sum;

    always_comb begin
        w_x_neg   = (r_corner == 2'd0) || (r_corner == CORNER_LAST);
        w_y_neg   = !r_corner[1];
        w_hc      = w_x_neg ? -r_c_hc : r_c_hc;
        w_hs      = w_x_neg ? -r_c_hs : r_c_hs;
        w_vc      = w_y_neg ? -r_c_vc : r_c_vc;
        w_vs      = w_y_neg ? -r_c_vs : r_c_vs;
        w_rx_full = 48'(w_hc) - 48'(w_vs);
        w_ry_full = 48'(w_hs) + 48'(w_vc);
        w_x_sum   = 34'(signed'(w_rx_full[47:15])) + 34'(r_c_pos_x);
        w_y_sum   = 34'(signed'(w_ry_full[47:15])) + 34'(r_c_pos_y);
    end

    // Output register: load on a free slot, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_out_free) begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_adv) begin
            r_o_x      <= sat32(w_x_sum);
            r_o_y      <= sat32(w_y_sum);
            r_o_u      <= w_x_neg ? r_c_u0 : r_c_u1;
            r_o_v      <= w_y_neg ? r_c_v1 : r_c_v0;
            r_o_col    <= r_c_col;
            r_o_corner <= r_corner;
            r_o_last   <= (r_corner == CORNER_LAST);
        end
    end

    assign o_vertex.valid        = r_o_vld;
    assign o_vertex.vertex_x     = r_o_x;
    assign o_vertex.vertex_y     = r_o_y;
    assign o_vertex.corner_u     = r_o_u;
    assign o_vertex.corner_v     = r_o_v;
    assign o_vertex.vertex_color = r_o_col;
    assign o_vertex.corner       = r_o_corner;
    assign o_vertex.last         = r_o_last;

`ifndef SYNTHESIS
    // Last flag marks corner three and nothing else
    a_last_on_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_last == (r_o_corner == CORNER_LAST)))
        else $error("last flag disagrees with corner number");

    // Corner iterator holds while the output is stalled
    a_corner_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && !w_out_free) |=> (r_c_vld && $stable(r_corner)))
        else $error("corner iterator moved under back-pressure");

    // Within a sprite the corner advances by one and the stage stays busy
    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_c_adv && r_corner != CORNER_LAST) |=>
            (r_c_vld && r_corner == $past(r_corner) + 2'd1))
        else $error("corner iterator skipped or dropped a corner");

    // A new sprite starts at corner zero
    a_corner_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_move |=> (r_c_vld && r_corner == 2'd0))
        else $error("sprite entered corner stage off corner zero");
`endif

endmodule

`default_nettype wire
